/* hw/rtl/mtbq_pkg.sv */
// mtbq_pkg: sizes, codes, state type and control bundles of the min tag buffer queue.
// Used by mtbq_cell, mtbq_scan and min_tag_buffer_queue; depends on nothing.
package mtbq_pkg;

    localparam int DEPTH = 16;
    localparam int TAG_W = 30;
    localparam int OCC_W = 5;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic en;
        logic clear;
    } scan_ctrl_t;

endpackage

/* hw/rtl/mtbq_cell.sv */
// mtbq_cell: one tag slot of the chain; loads a new tag or takes its neighbor's tag.
// Depends on mtbq_pkg.
module mtbq_cell (
    input  logic                clk,
    input  mtbq_pkg::cell_ctrl_t ctrl,
    input  mtbq_pkg::tag_t      load_tag,
    input  mtbq_pkg::tag_t      shift_in,
    output mtbq_pkg::tag_t      tag_out
);
    import mtbq_pkg::*;

    tag_t tag_reg;
    tag_t tag_next;

    always_comb
    begin
        tag_next = tag_reg;
        if (ctrl.load)
        begin
            tag_next = load_tag;
        end
        else if (ctrl.shift)
        begin
            tag_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tag_out = tag_reg;

endmodule

/* hw/rtl/mtbq_scan.sv */
// mtbq_scan: running minimum over the tags passing the chain head, first minimum wins.
// Depends on mtbq_pkg.
module mtbq_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtbq_pkg::scan_ctrl_t ctrl,
    input  mtbq_pkg::tag_t       head_tag,
    input  mtbq_pkg::idx_t       head_idx,
    output mtbq_pkg::tag_t       min_tag,
    output mtbq_pkg::idx_t       min_idx
);
    import mtbq_pkg::*;

    tag_t min_tag_reg;
    tag_t min_tag_next;
    idx_t min_idx_reg;
    idx_t min_idx_next;

    always_comb
    begin
        min_tag_next = min_tag_reg;
        min_idx_next = min_idx_reg;
        if (ctrl.en && (ctrl.clear || (head_tag < min_tag_reg)))
        begin
            min_tag_next = head_tag;
            min_idx_next = head_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        min_tag_reg <= min_tag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_idx_reg <= '0;
        end
        else
        begin
            min_idx_reg <= min_idx_next;
        end
    end

    assign min_tag = min_tag_reg;
    assign min_idx = min_idx_reg;

endmodule

/* hw/rtl/min_tag_buffer_queue.sv */
// min_tag_buffer_queue: top level, a ring of tag cells with a minimum scanner at its head.
// Depends on mtbq_pkg, mtbq_cell and mtbq_scan.
//
// A push into a table with room, and a pop of an empty table, leave busy low, and the
// result strobes on done in the next cycle. A push into a full table or a pop
// of a non-empty table rotates the whole ring of DEPTH cells once past the comparator at
// its head, then applies the overwrite or the close-up, with busy high throughout; done
// pulses in the same cycle that busy falls. The receiver cannot stall: each result is
// on found, popped_tag, evicted and occupancy from the done cycle until the next result.
module min_tag_buffer_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 command,
    input  mtbq_pkg::tag_t       tag,
    output logic                 done,
    output logic                 found,
    output mtbq_pkg::tag_t       popped_tag,
    output logic                 evicted,
    output logic [mtbq_pkg::OCC_W-1:0] occupancy
);
    import mtbq_pkg::*;

    state_t state_reg;
    state_t state_next;
    cnt_t   count_reg;
    cnt_t   count_next;
    idx_t   step_reg;
    idx_t   step_next;
    logic   op_reg;
    logic   op_next;
    tag_t   hold_reg;
    tag_t   hold_next;
    logic   done_reg;
    logic   done_next;
    logic   found_reg;
    logic   found_next;
    tag_t   popped_reg;
    tag_t   popped_next;
    logic   evicted_reg;
    logic   evicted_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cnt_t       scan_len;
    tag_t       load_tag;
    tag_t       min_tag;
    idx_t       min_idx;
    scan_ctrl_t scan_ctrl;
    tag_t       cell_tag [DEPTH];

    assign accept   = start && (state_reg == ST_IDLE);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign scan_len = (op_reg == CMD_POP) ? count_reg : CNT_W'(DEPTH);
    assign load_tag = (state_reg == ST_IDLE) ? tag : hold_reg;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            cell_ctrl_t cell_ctrl;

            always_comb
            begin
                cell_ctrl.load = 1'b0;
                cell_ctrl.shift = 1'b0;
                case (state_reg)
                    ST_IDLE:
                    begin
                        cell_ctrl.load = accept && (command == CMD_PUSH) && !is_full
                                         && (count_reg == CNT_W'(k));
                    end
                    ST_SCAN:
                    begin
                        cell_ctrl.shift = 1'b1;
                    end
                    ST_APPLY:
                    begin
                        cell_ctrl.load  = (op_reg == CMD_PUSH) && (min_idx == IDX_W'(k));
                        cell_ctrl.shift = (op_reg == CMD_POP) && (IDX_W'(k) >= min_idx);
                    end
                    default:
                    begin
                        cell_ctrl.load = 1'b0;
                    end
                endcase
            end

            mtbq_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .load_tag (load_tag),
                .shift_in (cell_tag[(k + 1) % DEPTH]),
                .tag_out  (cell_tag[k])
            );
        end
    endgenerate

    assign scan_ctrl.en    = (state_reg == ST_SCAN) && ({1'b0, step_reg} < scan_len);
    assign scan_ctrl.clear = (step_reg == '0);

    mtbq_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .head_tag (cell_tag[0]),
        .head_idx (step_reg),
        .min_tag  (min_tag),
        .min_idx  (min_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (((command == CMD_PUSH) && is_full)
                               || ((command == CMD_POP) && !is_empty)))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        count_next   = count_reg;
        step_next    = step_reg;
        op_next      = op_reg;
        hold_next    = hold_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        popped_next  = popped_reg;
        evicted_next = evicted_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    op_next   = command;
                    hold_next = tag;
                    if ((command == CMD_PUSH) && !is_full)
                    begin
                        count_next   = count_reg + CNT_W'(1);
                        done_next    = 1'b1;
                        found_next   = 1'b0;
                        popped_next  = '0;
                        evicted_next = 1'b0;
                    end
                    else if ((command == CMD_POP) && is_empty)
                    begin
                        done_next    = 1'b1;
                        found_next   = 1'b0;
                        popped_next  = '0;
                        evicted_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + IDX_W'(1);
            end
            ST_APPLY:
            begin
                done_next = 1'b1;
                if (op_reg == CMD_POP)
                begin
                    count_next   = count_reg - CNT_W'(1);
                    found_next   = 1'b1;
                    popped_next  = min_tag;
                    evicted_next = 1'b0;
                end
                else
                begin
                    found_next   = 1'b0;
                    popped_next  = '0;
                    evicted_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            op_reg    <= CMD_PUSH;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg    <= hold_next;
        found_reg   <= found_next;
        popped_reg  <= popped_next;
        evicted_reg <= evicted_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign popped_tag = popped_reg;
    assign evicted    = evicted_reg;
    assign occupancy  = OCC_W'(count_reg);

endmodule
